// File: design/dlg_pkg.sv
// ----------------------------------------------------------------------------
// dlg_pkg: shared types and constants for depth linearization to gray
// Field widths, datapath widths and the control word passed down the pipe.
// ----------------------------------------------------------------------------
package dlg_pkg;

   localparam int DEPTH_BITS = 24;
   localparam int SAMPLE_W   = 24;
   localparam int PLANE_W    = 32;
   localparam int GRAY_W     = 8;
   localparam int BIT_IDX_W  = $clog2(GRAY_W);

   localparam int A_W     = PLANE_W + DEPTH_BITS;
   localparam int A_LO_W  = A_W / 2;
   localparam int A_HI_W  = A_W - A_LO_W;
   localparam int NF_W    = 2 * PLANE_W;
   localparam int NF255_W = NF_W + GRAY_W;
   localparam int DEN_W   = A_W + PLANE_W;
   localparam int NUM_W   = NF255_W + DEPTH_BITS;

   localparam logic [DEPTH_BITS:0] DEPTH_ONE = {1'b1, {DEPTH_BITS{1'b0}}};
   localparam logic [GRAY_W-1:0]   GRAY_MAX  = {GRAY_W{1'b1}};
   localparam logic [GRAY_W-1:0]   GRAY_MIN  = '0;

   localparam logic REG_NEAR_PLANE = 1'b0;
   localparam logic REG_FAR_PLANE  = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              dis;    // linearization off, pass raw depth
      logic              eq;     // near equals far
      logic              neg;    // near beyond far
      logic              big;    // quotient reaches 256 or more
      logic [GRAY_W-1:0] raw;    // raw depth scaled to gray
   } ctl_type;

endpackage

// File: design/dlg_div_step.sv
// ----------------------------------------------------------------------------
// dlg_div_step: one restoring division stage
// Resolves one quotient bit against the divisor shifted by bit_idx.
// ----------------------------------------------------------------------------
module dlg_div_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [dlg_pkg::BIT_IDX_W-1:0]  bit_idx,
   input  dlg_pkg::ctl_type               ctl_i,
   input  logic [dlg_pkg::NUM_W-1:0]      rem_i,
   input  logic [dlg_pkg::DEN_W-1:0]      den_i,
   input  logic [dlg_pkg::GRAY_W-1:0]     quo_i,
   output dlg_pkg::ctl_type               ctl_o,
   output logic [dlg_pkg::NUM_W-1:0]      rem_o,
   output logic [dlg_pkg::DEN_W-1:0]      den_o,
   output logic [dlg_pkg::GRAY_W-1:0]     quo_o
);
   import dlg_pkg::*;

   logic [NUM_W-1:0]  sd;
   logic              ge;
   ctl_type           ctl_ff;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [GRAY_W-1:0] quo_ff, quo_in;

   assign sd     = NUM_W'(den_i) << bit_idx;
   assign ge     = (rem_i >= sd);
   assign rem_in = ge ? (rem_i - sd) : rem_i;
   assign quo_in = quo_i | (GRAY_W'(ge) << bit_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         quo_ff <= quo_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

// File: design/depth_linearize_to_gray.sv
// ----------------------------------------------------------------------------
// depth_linearize_to_gray: perspective depth linearization to a gray byte
// Undoes the perspective depth mapping with exact integer math and scales
// the linear depth to an 8-bit gray level with clamping.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one window depth sample per transaction; rsp_* returns
//   one gray level and a clamp flag per transaction, in order.
//   A transaction moves on a rising edge where valid is high and stall low.
//   csr_* writes near_plane (index 0) and far_plane (index 1), Q16.16;
//   either one zero passes the raw depth through. Write only while idle.
// Throughput: one transaction per cycle unless a held response stalls the pipe;
//   the datapath is a 14-stage pipe (planes setup, three multiply stages,
//   divisor assembly, wide compare, then one restoring division stage per
//   quotient bit) followed by the response register.
// Stall: the whole pipe freezes while a response waits under rsp_stall;
//   req_stall follows that condition, so nothing is lost or repeated.
// Reset: synchronous; clears all valid bits and both plane registers.
// ----------------------------------------------------------------------------
module depth_linearize_to_gray (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dlg_pkg::SAMPLE_W-1:0]  req_depth_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dlg_pkg::GRAY_W-1:0]    rsp_gray_level,
   output logic                          rsp_clamped,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [dlg_pkg::PLANE_W-1:0]   csr_wdata
);
   import dlg_pkg::*;

   logic advance;

   // Plane registers
   logic [PLANE_W-1:0] near_ff, far_ff;

   // Stage 1: classify, depth complement, plane gap
   ctl_type               s1_ctl_ff, s1_ctl_in;
   logic [DEPTH_BITS-1:0] s1_s_ff, s1_s_in;
   logic [DEPTH_BITS:0]   s1_dms_ff, s1_dms_in;
   logic [PLANE_W-1:0]    s1_gap_ff, s1_gap_in;

   // Stage 2: products F*(D-s), N*s, N*F and raw gray
   ctl_type               s2_ctl_ff, s2_ctl_in;
   logic [A_W-1:0]        s2_p1_ff, s2_p1_in;
   logic [A_W-1:0]        s2_p2_ff, s2_p2_in;
   logic [NF_W-1:0]       s2_nf_ff, s2_nf_in;
   logic [PLANE_W-1:0]    s2_gap_ff;
   logic [DEPTH_BITS+GRAY_W-1:0] raw_prod;

   // Stage 3: A sum and 255*N*F
   ctl_type               s3_ctl_ff;
   logic [A_W-1:0]        s3_a_ff, s3_a_in;
   logic [NF255_W-1:0]    s3_nf255_ff, s3_nf255_in;
   logic [PLANE_W-1:0]    s3_gap_ff;

   // Stage 4: split partial products of A*gap
   ctl_type                  s4_ctl_ff;
   logic [A_LO_W+PLANE_W-1:0] s4_pl_ff, s4_pl_in;
   logic [A_HI_W+PLANE_W-1:0] s4_ph_ff, s4_ph_in;
   logic [NF255_W-1:0]       s4_nf255_ff;

   // Stage 5: divisor assembly
   ctl_type             s5_ctl_ff;
   logic [DEN_W-1:0]    s5_den_ff, s5_den_in;
   logic [NF255_W-1:0]  s5_nf255_ff;

   // Stage 6: overflow compare, load the dividend
   ctl_type             s6_ctl_ff, s6_ctl_in;
   logic [NUM_W-1:0]    s6_num_ff, s6_num_in;
   logic [DEN_W-1:0]    s6_den_ff;

   // Division chain
   ctl_type             chain_ctl [0:GRAY_W];
   logic [NUM_W-1:0]    chain_rem [0:GRAY_W];
   logic [DEN_W-1:0]    chain_den [0:GRAY_W];
   logic [GRAY_W-1:0]   chain_quo [0:GRAY_W];

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [GRAY_W-1:0]   rsp_gray_ff, rsp_gray_in;
   logic                rsp_clamped_ff, rsp_clamped_in;

   // Freeze everything while a finished response is held off
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= '0;
         far_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_NEAR_PLANE: near_ff <= csr_wdata;
            REG_FAR_PLANE:  far_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1
   always_comb begin
      s1_ctl_in       = '0;
      s1_ctl_in.valid = req_valid;
      s1_ctl_in.dis   = (near_ff == '0) || (far_ff == '0);
      s1_ctl_in.eq    = (near_ff == far_ff);
      s1_ctl_in.neg   = (near_ff > far_ff);
   end
   assign s1_s_in   = DEPTH_BITS'(req_depth_sample);
   assign s1_dms_in = DEPTH_ONE - {1'b0, s1_s_in};
   assign s1_gap_in = (far_ff > near_ff) ? (far_ff - near_ff) : (near_ff - far_ff);

   // Stage 2
   assign raw_prod = {s1_s_ff, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, s1_s_ff};
   always_comb begin
      s2_ctl_in     = s1_ctl_ff;
      s2_ctl_in.raw = raw_prod[DEPTH_BITS+GRAY_W-1:DEPTH_BITS];
   end
   assign s2_p1_in = A_W'(far_ff) * A_W'(s1_dms_ff);
   assign s2_p2_in = A_W'(near_ff) * A_W'(s1_s_ff);
   assign s2_nf_in = NF_W'(near_ff) * NF_W'(far_ff);

   // Stage 3: 255*x as (x << 8) - x
   assign s3_a_in     = s2_p1_ff + s2_p2_ff;
   assign s3_nf255_in = {s2_nf_ff, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, s2_nf_ff};

   // Stage 4
   assign s4_pl_in = (A_LO_W+PLANE_W)'(s3_a_ff[A_LO_W-1:0]) * (A_LO_W+PLANE_W)'(s3_gap_ff);
   assign s4_ph_in = (A_HI_W+PLANE_W)'(s3_a_ff[A_W-1:A_LO_W]) * (A_HI_W+PLANE_W)'(s3_gap_ff);

   // Stage 5
   assign s5_den_in = DEN_W'(s4_pl_ff) + (DEN_W'(s4_ph_ff) << A_LO_W);

   // Stage 6: dividend is 255*N*F*2^DEPTH_BITS
   assign s6_num_in = {s5_nf255_ff, {DEPTH_BITS{1'b0}}};
   always_comb begin
      s6_ctl_in     = s5_ctl_ff;
      s6_ctl_in.big = (s6_num_in >= (NUM_W'(s5_den_ff) << GRAY_W));
   end

   // Valid bits and control words
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
         s6_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s4_ctl_ff;
         s6_ctl_ff <= s6_ctl_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_s_ff     <= s1_s_in;
         s1_dms_ff   <= s1_dms_in;
         s1_gap_ff   <= s1_gap_in;
         s2_p1_ff    <= s2_p1_in;
         s2_p2_ff    <= s2_p2_in;
         s2_nf_ff    <= s2_nf_in;
         s2_gap_ff   <= s1_gap_ff;
         s3_a_ff     <= s3_a_in;
         s3_nf255_ff <= s3_nf255_in;
         s3_gap_ff   <= s2_gap_ff;
         s4_pl_ff    <= s4_pl_in;
         s4_ph_ff    <= s4_ph_in;
         s4_nf255_ff <= s3_nf255_ff;
         s5_den_ff   <= s5_den_in;
         s5_nf255_ff <= s4_nf255_ff;
         s6_num_ff   <= s6_num_in;
         s6_den_ff   <= s5_den_ff;
      end
   end

   // Restoring division, most significant quotient bit first
   assign chain_ctl[0] = s6_ctl_ff;
   assign chain_rem[0] = s6_num_ff;
   assign chain_den[0] = s6_den_ff;
   assign chain_quo[0] = '0;

   for (genvar g = 0; g < GRAY_W; g++) begin : g_step
      dlg_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .bit_idx (BIT_IDX_W'(GRAY_W - 1 - g)),
         .ctl_i   (chain_ctl[g]),
         .rem_i   (chain_rem[g]),
         .den_i   (chain_den[g]),
         .quo_i   (chain_quo[g]),
         .ctl_o   (chain_ctl[g+1]),
         .rem_o   (chain_rem[g+1]),
         .den_o   (chain_den[g+1]),
         .quo_o   (chain_quo[g+1])
      );
   end

   // Pick the final gray level; the remainder of the last step is dropped
   always_comb begin
      rsp_valid_in = chain_ctl[GRAY_W].valid;
      if (chain_ctl[GRAY_W].dis) begin
         rsp_gray_in    = chain_ctl[GRAY_W].raw;
         rsp_clamped_in = 1'b0;
      end else if (chain_ctl[GRAY_W].eq) begin
         rsp_gray_in    = GRAY_MAX;
         rsp_clamped_in = 1'b1;
      end else if (chain_ctl[GRAY_W].neg) begin
         // negative depth: clamp to black, flag unless it truncates to zero
         rsp_gray_in    = GRAY_MIN;
         rsp_clamped_in = chain_ctl[GRAY_W].big || (chain_quo[GRAY_W] != '0);
      end else if (chain_ctl[GRAY_W].big) begin
         rsp_gray_in    = GRAY_MAX;
         rsp_clamped_in = 1'b1;
      end else begin
         rsp_gray_in    = chain_quo[GRAY_W];
         rsp_clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_gray_ff    <= rsp_gray_in;
         rsp_clamped_ff <= rsp_clamped_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_level = rsp_gray_ff;
   assign rsp_clamped    = rsp_clamped_ff;

   // chain_rem at the end of the chain is not needed
   logic unused_rem;
   assign unused_rem = ^{chain_rem[GRAY_W], chain_den[GRAY_W]};

endmodule

// File: design/dlg_checker.sv
// ----------------------------------------------------------------------------
// dlg_checker: port-level checks for depth_linearize_to_gray
// Watches handshakes and response values; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dlg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [dlg_pkg::GRAY_W-1:0]   rsp_gray_level,
   input logic                         rsp_clamped
);
   import dlg_pkg::*;

   // A held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gray_level) && $stable(rsp_clamped))
      else $error("response changed while stalled");

   // The pipe stalls the request side exactly when a response is held
   a_req_stall: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow response back-pressure");

   // A clamped result sits at an end of the gray range
   a_clamp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clamped |-> (rsp_gray_level == GRAY_MIN) || (rsp_gray_level == GRAY_MAX))
      else $error("clamped response not at range end");

   // Reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind depth_linearize_to_gray dlg_checker u_dlg_checker (.*);

// File: tb/depth_gray_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_gray_checker: result checker for depth linearization to gray
// Watches the plane writes and both channels. For every accepted depth
// sample it computes the gray level and clamp flag with exact wide integer
// math, queues them, and compares each accepted response with the oldest
// queued result.
// ----------------------------------------------------------------------------
module depth_gray_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [dlg_pkg::SAMPLE_W-1:0]  req_depth_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [dlg_pkg::GRAY_W-1:0]    rsp_gray_level,
   input  logic                          rsp_clamped,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [dlg_pkg::PLANE_W-1:0]   csr_wdata,
   output int                            mismatches,
   output int                            outstanding
);
   import dlg_pkg::*;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              clamped;
   } gray_pixel_type;

   logic [PLANE_W-1:0] near_shadow;
   logic [PLANE_W-1:0] far_shadow;
   gray_pixel_type     grays_due[$];
   int                 fail_total;

   // Exact form: 255*N*F*2^D / (A*|F-N|), A = F*(2^D - s) + N*s.
   function automatic gray_pixel_type linear_gray(input logic [SAMPLE_W-1:0] sample,
                                                  input logic [PLANE_W-1:0]  n,
                                                  input logic [PLANE_W-1:0]  f);
      logic [127:0]   s;
      logic [127:0]   depth_rest;
      logic [127:0]   span;
      logic [127:0]   denom;
      logic [127:0]   numer;
      logic [127:0]   quotient;
      gray_pixel_type px;
      s = 128'(sample[DEPTH_BITS-1:0]);
      px.clamped = 1'b0;
      if (n == '0 || f == '0) begin
         numer = (s * 128'd255) >> DEPTH_BITS;
         px.gray = numer[GRAY_W-1:0];
      end else if (n == f) begin
         px.gray    = GRAY_MAX;
         px.clamped = 1'b1;
      end else begin
         span       = (f > n) ? 128'(f - n) : 128'(n - f);
         depth_rest = 128'(DEPTH_ONE) - s;
         denom      = (128'(f) * depth_rest + 128'(n) * s) * span;
         numer      = (128'(n) * 128'(f) * 128'd255) << DEPTH_BITS;
         quotient   = numer / denom;
         if (f > n) begin
            if (quotient > 128'd255) begin
               px.gray    = GRAY_MAX;
               px.clamped = 1'b1;
            end else begin
               px.gray = quotient[GRAY_W-1:0];
            end
         end else begin
            // negative depth: anything that survives truncation is clamped
            px.gray    = GRAY_MIN;
            px.clamped = (quotient != '0);
         end
      end
      return px;
   endfunction

   always @(posedge clock) begin : watch
      gray_pixel_type got;
      gray_pixel_type want;
      if (reset) begin
         near_shadow = '0;
         far_shadow  = '0;
         grays_due.delete();
      end else begin
         if (req_valid && !req_stall)
            grays_due.push_back(linear_gray(req_depth_sample, near_shadow, far_shadow));
         if (rsp_valid && !rsp_stall) begin
            got.gray    = rsp_gray_level;
            got.clamped = rsp_clamped;
            if (grays_due.size() == 0) begin
               $display("%0t: unexpected response gray_level %0d clamped %0d",
                        $time, got.gray, got.clamped);
               fail_total++;
            end else begin
               want = grays_due.pop_front();
               if (want.gray !== got.gray) begin
                  $display("%0t: gray_level expected %0d actual %0d",
                           $time, want.gray, got.gray);
                  fail_total++;
               end
               if (want.clamped !== got.clamped) begin
                  $display("%0t: clamped expected %0d actual %0d",
                           $time, want.clamped, got.clamped);
                  fail_total++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_NEAR_PLANE: near_shadow = csr_wdata;
               REG_FAR_PLANE:  far_shadow  = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding <= grays_due.size();
      mismatches  <= fail_total;
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for depth_linearize_to_gray
// Programs near and far planes across disabled, equal, reversed, typical
// and extreme settings, streams directed and random depth samples with
// random gaps and response stalls, and reports the checker's result.
// ----------------------------------------------------------------------------
module testbench;
   import dlg_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_depth_sample;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [GRAY_W-1:0]   rsp_gray_level;
   logic                rsp_clamped;
   logic                csr_wr_en;
   logic                csr_index;
   logic [PLANE_W-1:0]  csr_wdata;

   int mismatches;
   int outstanding;

   // Idling controls for the sender and the receiver.
   bit gaps_on   = 1'b1;
   bit stalls_on = 1'b1;
   bit hold_request = 1'b0;

   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 60;
   localparam int RANDOM_PHASES = 8;
   localparam int TAIL_CYCLES  = 24;

   depth_linearize_to_gray i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_depth_sample (req_depth_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gray_level   (rsp_gray_level),
      .rsp_clamped      (rsp_clamped),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   depth_gray_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_depth_sample (req_depth_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gray_level   (rsp_gray_level),
      .rsp_clamped      (rsp_clamped),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one depth sample and hold it until the transaction is taken.
   // Entered and left at a falling edge; an optional random gap comes first.
   task automatic send_depth(input logic [SAMPLE_W-1:0] sample);
      while (gaps_on && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_depth_sample <= sample;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every queued response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Write the near plane, then the far plane, back to back; only while idle.
   task automatic program_planes(input logic [PLANE_W-1:0] near_q,
                                 input logic [PLANE_W-1:0] far_q);
      csr_wr_en <= 1'b1;
      csr_index <= REG_NEAR_PLANE;
      csr_wdata <= near_q;
      @(negedge clock);
      csr_index <= REG_FAR_PLANE;
      csr_wdata <= far_q;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Plane pairs by flavor: typical, fully random, reversed, equal,
   // one side off, and nearly equal.
   task automatic pick_planes(input int mode,
                              output logic [PLANE_W-1:0] near_q,
                              output logic [PLANE_W-1:0] far_q);
      case (mode)
         0: begin
            near_q = $urandom_range(1, 32'h0002_0000);
            far_q  = $urandom_range(32'h0004_0000, 32'h7FFF_FFFF);
         end
         1: begin
            near_q = $urandom;
            far_q  = $urandom;
         end
         2: begin
            far_q  = $urandom_range(1, 32'h0001_0000);
            near_q = far_q + $urandom_range(1, 32'h0010_0000);
         end
         3: begin
            near_q = $urandom;
            far_q  = near_q;
         end
         4: begin
            if ($urandom_range(0, 1) == 0) begin
               near_q = '0;
               far_q  = $urandom;
            end else begin
               near_q = $urandom;
               far_q  = '0;
            end
         end
         default: begin
            near_q = $urandom_range(1, 32'hFFFF_0000);
            far_q  = near_q + $urandom_range(1, 255);
         end
      endcase
   endtask

   // Favor samples close to one, where the linear depth changes fastest.
   function automatic logic [SAMPLE_W-1:0] random_depth;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         return SAMPLE_W'($urandom);
      else if (pick < 9)
         return {SAMPLE_W{1'b1}} - SAMPLE_W'($urandom_range(0, 32'h0003_FFFF));
      else
         return ($urandom_range(0, 1) == 0) ? '0 : {SAMPLE_W{1'b1}};
   endfunction

   // Receiver: random stalls, plus one long hold-off on request so the
   // pipe fills and backs up into req_stall.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_stall <= stalls_on && ($urandom_range(0, 99) < 36);
         end
      end
   end

   initial begin : stimulus
      logic [PLANE_W-1:0] near_q;
      logic [PLANE_W-1:0] far_q;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_depth_sample = '0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_NEAR_PLANE;
      csr_wdata        = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Planes at reset value: raw depth passes straight through.
      send_depth('0);
      send_depth({SAMPLE_W{1'b1}});
      send_depth(24'h00_0001);
      send_depth(24'h80_0000);
      drain;

      // Near 0.1, far 100: normal range, and large values near depth one.
      program_planes(32'h0000_1999, 32'h0064_0000);
      send_depth('0);
      send_depth(24'h80_0000);
      send_depth(24'hFF_FFF0);
      send_depth({SAMPLE_W{1'b1}});
      drain;

      // Near equal to far: saturate with the flag set.
      program_planes(32'h0001_0000, 32'h0001_0000);
      send_depth('0);
      send_depth({SAMPLE_W{1'b1}});
      drain;

      // Near beyond far: negative depth, clamped or truncated to zero.
      program_planes(32'h0001_0000, 32'h0000_0001);
      send_depth('0);
      send_depth(24'hFF_FFF0);
      send_depth({SAMPLE_W{1'b1}});
      drain;

      // One plane zero: linearization is off.
      program_planes('0, 32'h0064_0000);
      send_depth({SAMPLE_W{1'b1}});
      drain;
      program_planes(32'h0000_1999, '0);
      send_depth(24'h80_0000);
      drain;

      // Register extremes.
      program_planes(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_depth('0);
      send_depth({SAMPLE_W{1'b1}});
      drain;
      program_planes(32'h0000_0001, 32'hFFFF_FFFF);
      send_depth('0);
      send_depth({SAMPLE_W{1'b1}});
      drain;

      // Random phases; each one pauses the sender until the pipe drains.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_planes((phase < 6) ? phase : $urandom_range(0, 5), near_q, far_q);
         program_planes(near_q, far_q);
         // one phase runs flat out on both sides
         gaps_on   = (phase != 3);
         stalls_on = (phase != 3);
         // another holds the receiver off while the sender keeps pushing
         if (phase == 5) begin
            gaps_on      = 1'b0;
            hold_request = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_depth(random_depth());
         drain;
      end

      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("depth_linearize_to_gray: match");
      else
         $display("depth_linearize_to_gray: mismatch");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("depth_linearize_to_gray: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
design/dlg_pkg.sv
design/dlg_div_step.sv
design/depth_linearize_to_gray.sv
design/dlg_checker.sv
tb/depth_gray_checker.sv
tb/testbench.sv
